// ===== design/pdgr_pkg.sv =====
// pdgr_pkg: shared types and constants of the pcm ducking gain ramp.
// Used by the channel interfaces and the core; no dependencies.
package pdgr_pkg;

	localparam int SAMPLE_W = 16;
	localparam int GAIN_W   = 16;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 2;

	// q1.15 unity gain
	localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'h8000;

	typedef enum logic {
		KIND_SAMPLE = 1'b0,
		KIND_DUCK   = 1'b1
	} item_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DUCK_FLOOR    = 2'd0,
		REG_FADE_OUT_STEP = 2'd1,
		REG_FADE_IN_STEP  = 2'd2
	} cfg_reg_t;

endpackage

// ===== design/pdgr_if.sv =====
// pdgr_item_if and pdgr_result_if: valid/ready channels of the ducking gain ramp.
// Depend on pdgr_pkg for field widths.
interface pdgr_item_if
	import pdgr_pkg::*;
;
	logic                       valid;
	logic                       ready;
	logic                       kind;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       end_of_segment;
	logic                       duck_enable;
	logic                       playing;

	modport source (output valid, kind, sample, end_of_segment, duck_enable, playing,
		input ready);
	modport sink (input valid, kind, sample, end_of_segment, duck_enable, playing,
		output ready);
endinterface

interface pdgr_result_if
	import pdgr_pkg::*;
;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic                       segment_last;

	modport source (output valid, sample_out, segment_last, input ready);
	modport sink (input valid, sample_out, segment_last, output ready);
endinterface

// ===== design/pcm_ducking_gain_ramp_core.sv =====
// pcm_ducking_gain_ramp_core: linear ducking gain ramp on a signed 16-bit pcm stream.
// Depends on pdgr_pkg and the channel interfaces in pdgr_if.sv.
//
// Usage:
//   item    valid/ready input channel; kind selects audio sample or duck command.
//   result  valid/ready output channel; one transfer per audio sample, none for a
//           duck command.
//   cfg_*   write port for duck_floor, fade_out_step and fade_in_step; write only
//           while the block is idle.
// On an accepted sample the gain takes its step in the same cycle (compare and add
// against the gain register), the sample and new gain are registered, and the
// 16x15 gain multiply sits between that register and the result register.
// Throughput: one item per cycle while the result receiver does not stall, set by the gain update loop.
// A duck command updates the duck flag (and snaps the gain when not playing) at
// its transfer and frees the slot at once.
// When the receiver stalls, both stages hold and item.ready falls only once both
// are full; nothing is dropped.
// Reset: gain goes to unity, duck flag clears, config registers take their reset values,
// the pipeline empties.
module pcm_ducking_gain_ramp_core
	import pdgr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wr_data,
	pdgr_item_if.sink            item,
	pdgr_result_if.source        result
);

	logic [GAIN_W-1:0] duck_floor_q;
	logic [GAIN_W-1:0] fade_out_step_q;
	logic [GAIN_W-1:0] fade_in_step_q;
	logic [GAIN_W-1:0] gain_q;
	logic              duck_flag_q;

	logic                       vld_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic                       last_s1;
	logic [GAIN_W-1:0]          gain_s1;

	logic                       vld_s2;
	logic signed [SAMPLE_W-1:0] sample_s2;
	logic                       last_s2;

	logic advance;
	logic accept;
	logic is_sample;

	logic [GAIN_W:0]   down_diff;
	logic [GAIN_W:0]   up_sum;
	logic [GAIN_W-1:0] gain_next;

	logic [SAMPLE_W-1:0]   mag;
	logic [SAMPLE_W+14:0]  prod;
	logic [SAMPLE_W-1:0]   q;
	logic [SAMPLE_W-1:0]   scaled;

	assign advance      = !vld_s2 || result.ready;
	assign item.ready   = !vld_s1 || advance;
	assign accept       = item.valid && item.ready;
	assign is_sample    = (item.kind == KIND_SAMPLE);

	// gain step for the incoming sample, no partial steps
	assign down_diff = {1'b0, gain_q} - {1'b0, fade_out_step_q};
	assign up_sum    = {1'b0, gain_q} + {1'b0, fade_in_step_q};

	always_comb begin
		gain_next = gain_q;
		if (duck_flag_q) begin
			if (!down_diff[GAIN_W] && (down_diff[GAIN_W-1:0] >= duck_floor_q)) begin
				gain_next = down_diff[GAIN_W-1:0];
			end
		end else begin
			if (up_sum <= {1'b0, GAIN_UNITY}) begin
				gain_next = up_sum[GAIN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duck_floor_q    <= 16'd8192;
			fade_out_step_q <= 16'd8;
			fade_in_step_q  <= 16'd4;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_DUCK_FLOOR:    duck_floor_q    <= cfg_wr_data;
				REG_FADE_OUT_STEP: fade_out_step_q <= cfg_wr_data;
				REG_FADE_IN_STEP:  fade_in_step_q  <= cfg_wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q      <= GAIN_UNITY;
			duck_flag_q <= 1'b0;
		end else if (accept) begin
			if (is_sample) begin
				gain_q <= gain_next;
			end else begin
				duck_flag_q <= item.duck_enable;
				if (!item.playing) begin
					gain_q <= item.duck_enable ? duck_floor_q : GAIN_UNITY;
				end
			end
		end
	end

	// stage 1: sample with its stepped gain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (item.ready) begin
			vld_s1 <= accept && is_sample;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_sample) begin
			sample_s1 <= item.sample;
			last_s1   <= item.end_of_segment;
			gain_s1   <= gain_next;
		end
	end

	// stage 2: sign-magnitude multiply, truncation toward zero
	assign mag  = sample_s1[SAMPLE_W-1] ? (~sample_s1 + SAMPLE_W'(1)) : sample_s1;
	assign prod = {15'd0, mag} * {16'd0, gain_s1[GAIN_W-2:0]};
	assign q    = prod[SAMPLE_W+14:15];
	assign scaled = sample_s1[SAMPLE_W-1] ? (~q + SAMPLE_W'(1)) : q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && vld_s1) begin
			sample_s2 <= (gain_s1 < GAIN_UNITY) ? $signed(scaled) : sample_s1;
			last_s2   <= last_s1;
		end
	end

	assign result.valid        = vld_s2;
	assign result.sample_out   = sample_s2;
	assign result.segment_last = last_s2;

endmodule
